### hw/rtl/fronthaul_grant_matcher_macros.svh
// Assertion helpers for the grant matcher.
`ifndef FRONTHAUL_GRANT_MATCHER_MACROS_SVH
`define FRONTHAUL_GRANT_MATCHER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FGM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grant matcher check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FGM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grant matcher check failed");

`endif

### hw/rtl/fgm_pkg.sv
package fgm_pkg;

  // Field widths of one input item.
  localparam int unsigned FrameW = 8;
  localparam int unsigned SubW   = 4;
  localparam int unsigned SlotW  = 6;
  localparam int unsigned SymW   = 4;
  localparam int unsigned PrbW   = 10;
  localparam int unsigned NumW   = 8;
  localparam int unsigned KeyW   = FrameW + SubW + SlotW + SymW;

  // Field widths of one result item.
  localparam int unsigned CovW = 16;
  localparam int unsigned CntW = 32;

  // Packed stream widths.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 120;

  // Input item kinds.
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_GRANT   = 2'd1,
    STAT_OUT_RANGE  = 2'd2,
    STAT_TABLE_FULL = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_EXEC = 3'b100
  } state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;
    logic look;
    logic exec;
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic out_busy;
    logic table_full;
  } stat_t;

endpackage

### hw/rtl/fgm_ctrl.sv
module fgm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fgm_pkg::stat_t stat_i,
  output fgm_pkg::cmd_t  cmd_o
);

  fgm_pkg::state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      fgm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = fgm_pkg::ST_LOOK;
        end
      end
      fgm_pkg::ST_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = fgm_pkg::ST_EXEC;
      end
      fgm_pkg::ST_EXEC: begin
        // Wait until the output register can take the result.
        if (!stat_i.out_busy) begin
          cmd_o.exec = 1'b1;
          state_d    = fgm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fgm_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fgm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/fgm_dp.sv
module fgm_dp #(
  parameter int unsigned GRANT_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fgm_pkg::cmd_t                 cmd_i,
  output fgm_pkg::stat_t                stat_o,
  input  logic                          in_mode_i,
  input  logic [fgm_pkg::InDataW-1:0]   in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [fgm_pkg::OutDataW-1:0]  out_data_o
);

  localparam int unsigned IdxW = (GRANT_ENTRIES > 1) ? $clog2(GRANT_ENTRIES) : 1;
  localparam int unsigned EndW = fgm_pkg::PrbW + 1;

  // Captured input item.
  logic                        mode_q;
  logic [fgm_pkg::KeyW-1:0]    key_q;
  logic [fgm_pkg::PrbW-1:0]    first_q;
  logic [fgm_pkg::NumW-1:0]    num_q;

  // Grant table.
  logic [GRANT_ENTRIES-1:0]    valid_q;
  logic [fgm_pkg::KeyW-1:0]    gkey_q   [GRANT_ENTRIES];
  logic [fgm_pkg::PrbW-1:0]    gfirst_q [GRANT_ENTRIES];
  logic [fgm_pkg::NumW-1:0]    gtotal_q [GRANT_ENTRIES];
  logic [fgm_pkg::CovW-1:0]    gcov_q   [GRANT_ENTRIES];

  // Lookup results.
  logic            hit, free;
  logic [IdxW-1:0] hit_idx, free_idx;
  logic            sel_hit_q, sel_free_q;
  logic [IdxW-1:0] sel_idx_q;

  // Counters and output register.
  logic [fgm_pkg::CntW-1:0] orphan_q, rfail_q, match_q;
  logic [fgm_pkg::CntW-1:0] orphan_d, rfail_d, match_d;
  logic                     out_valid_q;
  fgm_pkg::status_e         status_q, status_d;
  logic                     done_q, done_d;
  logic [fgm_pkg::CovW-1:0] cov_out_q, cov_out_d;

  // Entry update controls.
  logic                     wr_add, wr_cov;
  logic [fgm_pkg::CovW-1:0] cov_new;
  logic [EndW-1:0]          span_end, grant_end;
  logic [fgm_pkg::PrbW-1:0] g_first;
  logic [fgm_pkg::NumW-1:0] g_total;
  logic [fgm_pkg::CovW-1:0] g_cov;

  // Input capture; key is frame, subframe, slot, symbol from high to low.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= in_mode_i;
      key_q   <= {in_data_i[7:0], in_data_i[11:8], in_data_i[17:12], in_data_i[21:18]};
      first_q <= in_data_i[31:22];
      num_q   <= in_data_i[39:32];
    end
  end

  // Parallel key compare; the lowest matching and lowest free entries win.
  always_comb begin
    hit      = 1'b0;
    free     = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = GRANT_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (gkey_q[i] == key_q)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free     = 1'b1;
        free_idx = IdxW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      sel_hit_q  <= hit;
      sel_free_q <= free;
      sel_idx_q  <= hit ? hit_idx : free_idx;
    end
  end

  // Read the selected entry and form the result.
  assign g_first   = gfirst_q[sel_idx_q];
  assign g_total   = gtotal_q[sel_idx_q];
  assign g_cov     = gcov_q[sel_idx_q];
  assign span_end  = {1'b0, first_q} + {{(EndW - fgm_pkg::NumW){1'b0}}, num_q};
  assign grant_end = {1'b0, g_first} + {{(EndW - fgm_pkg::NumW){1'b0}}, g_total};
  assign cov_new   = g_cov + {{(fgm_pkg::CovW - fgm_pkg::NumW){1'b0}}, num_q};

  always_comb begin
    wr_add    = 1'b0;
    wr_cov    = 1'b0;
    status_d  = fgm_pkg::STAT_OK;
    done_d    = 1'b0;
    cov_out_d = '0;
    orphan_d  = orphan_q;
    rfail_d   = rfail_q;
    match_d   = match_q;
    if (mode_q == fgm_pkg::MODE_ADD) begin
      if (sel_hit_q || sel_free_q) begin
        wr_add = cmd_i.exec;
        done_d = (num_q == '0);
      end else begin
        status_d = fgm_pkg::STAT_TABLE_FULL;
      end
    end else if (!sel_hit_q) begin
      status_d = fgm_pkg::STAT_NO_GRANT;
      orphan_d = orphan_q + 1'b1;
    end else if ((first_q < g_first) || (span_end > grant_end)) begin
      status_d  = fgm_pkg::STAT_OUT_RANGE;
      rfail_d   = rfail_q + 1'b1;
      cov_out_d = g_cov;
      done_d    = (g_cov >= {{(fgm_pkg::CovW - fgm_pkg::NumW){1'b0}}, g_total});
    end else begin
      wr_cov    = cmd_i.exec;
      match_d   = match_q + 1'b1;
      cov_out_d = cov_new;
      done_d    = (cov_new >= {{(fgm_pkg::CovW - fgm_pkg::NumW){1'b0}}, g_total});
    end
  end

  // Table contents; written only by an executing item.
  always_ff @(posedge clk_i) begin
    if (wr_add) begin
      gkey_q[sel_idx_q]   <= key_q;
      gfirst_q[sel_idx_q] <= first_q;
      gtotal_q[sel_idx_q] <= num_q;
      gcov_q[sel_idx_q]   <= '0;
    end else if (wr_cov) begin
      gcov_q[sel_idx_q]   <= cov_new;
    end
  end

  // Valid bits and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      orphan_q <= '0;
      rfail_q  <= '0;
      match_q  <= '0;
    end else begin
      if (wr_add) begin
        valid_q[sel_idx_q] <= 1'b1;
      end
      if (cmd_i.exec) begin
        orphan_q <= orphan_d;
        rfail_q  <= rfail_d;
        match_q  <= match_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q  <= status_d;
      done_q    <= done_d;
      cov_out_q <= cov_out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = {5'b0, match_q, rfail_q, orphan_q, cov_out_q, done_q, status_q};
  assign stat_o.out_busy   = out_valid_q && !out_ready_i;
  assign stat_o.table_full = &valid_q;

endmodule

### hw/rtl/fronthaul_grant_matcher.sv
// Fronthaul grant matcher.
// Input stream: one item per header. tuser carries the mode (0 adds or
// replaces a control-plane grant, 1 checks a user-plane header); tdata
// carries the key and the PRB span. Output stream: one result per item
// with the status, the completion flag of the addressed grant, its
// covered PRB count and the three outcome counters.
// An accepted item is first captured; then the parallel key compare over
// all entries is registered; then the selected entry is read and updated
// and the output register is loaded. One item is in work at a time, so a
// new item is accepted only after the last one has loaded its result into
// the output register.
// The result sits in an output register; the next item is accepted while
// it waits. If the receiver stalls, the following item stops in its
// update step until the register is free, and the input is not ready.
// Reset clears all grant valid bits and the counters; no clearing pass is
// needed, and items are accepted from the first cycle after reset.
`include "fronthaul_grant_matcher_macros.svh"

module fronthaul_grant_matcher #(
  parameter int unsigned GRANT_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // frame_no[7:0], subframe_no[11:8], slot_id[17:12], symbol_no[21:18],
  // first_prb[31:22], num_prb[39:32]
  input  logic [fgm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // mode[0]
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status[1:0], grant_done[2], covered_now[18:3], orphan_count[50:19],
  // range_fail_count[82:51], matched_count[114:83], zero fill[119:115]
  output logic [fgm_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  fgm_pkg::cmd_t  cmd;
  fgm_pkg::stat_t stat;

  // Sequencing of each item.
  fgm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Grant table, counters and output register.
  fgm_dp #(
    .GRANT_ENTRIES (GRANT_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_mode_i   (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // One item at a time: no acceptance right after an accepted item.
  `FGM_ASSERT_NXT(a_one_item, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // An executing item always leaves a valid result behind.
  `FGM_ASSERT_NXT(a_exec_result, cmd.exec, m_axis_tvalid_o)
  // A full-table report only occurs when every entry is in use.
  `FGM_ASSERT_IMP(a_full_real,
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == fgm_pkg::STAT_TABLE_FULL), stat.table_full)

endmodule

### tb/fronthaul_grant_matcher_test.sv
`timescale 1ns / 100ps

module fronthaul_grant_matcher_test;
  import fgm_pkg::*;

  localparam int unsigned GRANT_N     = 16;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 12;
  localparam int unsigned MAX_REPORTS = 10;

  // One input item: the mode travels in tuser, the rest in tdata.
  typedef struct packed {
    logic              mode;
    logic [FrameW-1:0] frame;
    logic [SubW-1:0]   sub;
    logic [SlotW-1:0]  slot;
    logic [SymW-1:0]   sym;
    logic [PrbW-1:0]   first_prb;
    logic [NumW-1:0]   num_prb;
  } header_t;

  // One result item as carried on the output tdata.
  typedef struct packed {
    status_e         status;
    logic            done;
    logic [CovW-1:0] covered;
    logic [CntW-1:0] orphans;
    logic [CntW-1:0] range_fails;
    logic [CntW-1:0] matched;
  } verdict_t;

  // A directed row; the verdict is only used where typed is set.
  typedef struct packed {
    header_t  hdr;
    logic     typed;
    verdict_t verdict;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                s_axis_tuser_i  = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  // Mirror of the grant table and the outcome counters.
  logic              tbl_valid   [GRANT_N];
  logic [KeyW-1:0]   tbl_key     [GRANT_N];
  logic [PrbW-1:0]   tbl_first   [GRANT_N];
  logic [NumW-1:0]   tbl_total   [GRANT_N];
  logic [CovW-1:0]   tbl_covered [GRANT_N];
  logic [CntW-1:0]   orphan_cnt      = '0;
  logic [CntW-1:0]   range_fail_cnt  = '0;
  logic [CntW-1:0]   match_cnt       = '0;

  verdict_t    pending_verdicts[$];
  dir_row_t    directed_rows[$];
  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned hold_req       = 0;

  fronthaul_grant_matcher #(
    .GRANT_ENTRIES(GRANT_N)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic header_t make_hdr(logic mode, logic [KeyW-1:0] key,
                                       logic [PrbW-1:0] first_prb, logic [NumW-1:0] num_prb);
    header_t h;
    h.mode      = mode;
    {h.frame, h.sub, h.slot, h.sym} = key;
    h.first_prb = first_prb;
    h.num_prb   = num_prb;
    return h;
  endfunction

  function automatic verdict_t make_verdict(status_e status, logic done,
                                            logic [CovW-1:0] covered, logic [CntW-1:0] orphans,
                                            logic [CntW-1:0] range_fails,
                                            logic [CntW-1:0] matched);
    verdict_t v;
    v.status      = status;
    v.done        = done;
    v.covered     = covered;
    v.orphans     = orphans;
    v.range_fails = range_fails;
    v.matched     = matched;
    return v;
  endfunction

  // Applies one item to the mirrored grant table and returns the result it causes.
  function automatic verdict_t predict_grant_verdict(header_t h);
    logic [KeyW-1:0] key;
    int              hit;
    int              free_idx;
    int              i;
    int unsigned     grant_end;
    int unsigned     span_end;
    verdict_t        v;
    key      = {h.frame, h.sub, h.slot, h.sym};
    hit      = -1;
    free_idx = -1;
    for (i = 0; i < GRANT_N; i++) begin
      if (tbl_valid[i] && tbl_key[i] == key && hit < 0) hit = i;
      if (!tbl_valid[i] && free_idx < 0) free_idx = i;
    end
    v        = '0;
    v.status = STAT_OK;
    if (h.mode == MODE_ADD) begin
      // An add replaces the grant with the same key, else takes the lowest free entry.
      if (hit < 0) hit = free_idx;
      if (hit < 0) begin
        v.status = STAT_TABLE_FULL;
      end else begin
        tbl_valid[hit]   = 1'b1;
        tbl_key[hit]     = key;
        tbl_first[hit]   = h.first_prb;
        tbl_total[hit]   = h.num_prb;
        tbl_covered[hit] = '0;
        v.done           = (h.num_prb == 0);
      end
    end else if (hit < 0) begin
      v.status   = STAT_NO_GRANT;
      orphan_cnt = orphan_cnt + 1;
    end else begin
      grant_end = tbl_first[hit] + tbl_total[hit];
      span_end  = h.first_prb + h.num_prb;
      if (h.first_prb < tbl_first[hit] || span_end > grant_end) begin
        v.status       = STAT_OUT_RANGE;
        range_fail_cnt = range_fail_cnt + 1;
      end else begin
        tbl_covered[hit] = tbl_covered[hit] + h.num_prb;
        match_cnt        = match_cnt + 1;
      end
      v.covered = tbl_covered[hit];
      v.done    = (tbl_covered[hit] >= tbl_total[hit]);
    end
    v.orphans     = orphan_cnt;
    v.range_fails = range_fail_cnt;
    v.matched     = match_cnt;
    return v;
  endfunction

  // Offers one item, waits for the handshake and records the expected result.
  task automatic send_header(header_t h, logic typed, verdict_t typed_verdict);
    verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= h.mode;
    s_axis_tdata_i  <= {h.num_prb, h.first_prb, h.sym, h.slot, h.sub, h.frame};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    v = predict_grant_verdict(h);
    pending_verdicts.push_back(typed ? typed_verdict : v);
    items_sent++;
  endtask

  task automatic send_random(logic mode, logic [KeyW-1:0] key, int unsigned first_prb,
                             int unsigned num_prb);
    send_header(make_hdr(mode, key, PrbW'(first_prb), NumW'(num_prb)), 1'b0, '0);
  endtask

  // Mostly grant refreshes followed by checks that land inside the grant, plus noise.
  task automatic random_traffic(int unsigned quota);
    int unsigned     stop_at;
    int unsigned     pick;
    int unsigned     n_checks;
    int unsigned     k;
    int unsigned     first;
    int unsigned     total;
    int unsigned     st;
    int unsigned     room;
    logic [KeyW-1:0] key;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      key  = tbl_key[$urandom_range(0, GRANT_N - 1)];
      if (pick < 60) begin
        first = $urandom_range(0, 1023);
        total = $urandom_range(0, 255);
        send_random(MODE_ADD, key, first, total);
        n_checks = $urandom_range(1, 6);
        for (k = 0; k < n_checks; k++) begin
          if ($urandom_range(0, 3) != 0) begin
            st = first + $urandom_range(0, total);
            if (st > 1023) st = 1023;
            room = first + total - st;
            if (room > 255) room = 255;
            send_random(MODE_CHECK, key, st, $urandom_range(0, room));
          end else begin
            send_random(MODE_CHECK, key, $urandom_range(0, 1023), $urandom_range(0, 255));
          end
        end
      end else if (pick < 80) begin
        send_random(MODE_CHECK, key, $urandom_range(0, 1023), $urandom_range(0, 255));
      end else if (pick < 90) begin
        send_random(MODE_ADD, KeyW'($urandom), $urandom_range(0, 1023),
                    $urandom_range(0, 255));
      end else begin
        send_random(MODE_CHECK, KeyW'($urandom), $urandom_range(0, 1023),
                    $urandom_range(0, 255));
      end
    end
  endtask

  // Full-width checks on one grant until its covered count wraps past 65535.
  task automatic covered_wrap_burst();
    logic [KeyW-1:0] key;
    int unsigned     k;
    key = tbl_key[$urandom_range(0, GRANT_N - 1)];
    send_random(MODE_ADD, key, 0, 255);
    for (k = 0; k < 260; k++) send_random(MODE_CHECK, key, 0, 255);
  endtask

  // Directed rows: empty table, extremes of key and range, replacement, filling up.
  task automatic build_directed_rows();
    logic [KeyW-1:0] key_zero;
    logic [KeyW-1:0] key_max;
    logic [KeyW-1:0] key_new;
    logic [KeyW-1:0] key_fill;
    verdict_t        none;
    int unsigned     i;
    key_zero = '0;
    key_max  = '1;
    key_new  = {8'd1, 4'd2, 6'd3, 4'd4};
    none     = make_verdict(STAT_OK, 1'b0, 0, 0, 0, 0);
    directed_rows.push_back({make_hdr(MODE_CHECK, key_zero, 0, 0), 1'b1,
                             make_verdict(STAT_NO_GRANT, 1'b0, 0, 1, 0, 0)});
    directed_rows.push_back({make_hdr(MODE_ADD, key_zero, 0, 0), 1'b1,
                             make_verdict(STAT_OK, 1'b1, 0, 1, 0, 0)});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_zero, 0, 0), 1'b1,
                             make_verdict(STAT_OK, 1'b1, 0, 1, 0, 1)});
    directed_rows.push_back({make_hdr(MODE_ADD, key_max, 1023, 255), 1'b1,
                             make_verdict(STAT_OK, 1'b0, 0, 1, 0, 1)});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_max, 1023, 255), 1'b1,
                             make_verdict(STAT_OK, 1'b1, 255, 1, 0, 2)});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_max, 1022, 1), 1'b1,
                             make_verdict(STAT_OUT_RANGE, 1'b1, 255, 1, 1, 2)});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_zero, 1, 0), 1'b0, none});
    directed_rows.push_back({make_hdr(MODE_ADD, key_max, 100, 10), 1'b0, none});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_max, 105, 6), 1'b0, none});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_max, 100, 10), 1'b0, none});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_max, 104, 3), 1'b0, none});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_new, 512, 128), 1'b0, none});
    for (i = 1; i <= GRANT_N - 2; i++) begin
      key_fill = {8'(i * 17), 4'(i), 6'(i * 4 + 3), 4'(15 - i)};
      directed_rows.push_back({make_hdr(MODE_ADD, key_fill, PrbW'(i * 60), NumW'(i * 15)),
                               1'b0, none});
    end
    // The table is full now, so a new key is refused.
    directed_rows.push_back({make_hdr(MODE_ADD, key_new, 512, 128), 1'b1,
                             make_verdict(STAT_TABLE_FULL, 1'b0, 0, 2, 3, 4)});
    directed_rows.push_back({make_hdr(MODE_CHECK, key_new, 512, 128), 1'b0, none});
  endtask

  // Reset, stimulus phases and the final verdict.
  initial begin
    foreach (tbl_valid[n]) tbl_valid[n] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_directed_rows();
    tx_idle_pct  = 20;
    rx_stall_pct = 81;
    foreach (directed_rows[i]) begin
      send_header(directed_rows[i].hdr, directed_rows[i].typed, directed_rows[i].verdict);
    end
    random_traffic(640);
    tx_idle_pct  = 81;
    rx_stall_pct = 20;
    random_traffic(640);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req++;
    random_traffic(350);
    covered_wrap_burst();
    random_traffic(100);
    s_axis_tvalid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: random stalls, and one long hold-off when asked for.
  initial begin
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Result checker: each accepted result against the oldest expectation.
  initial begin
    verdict_t want;
    verdict_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        got.status      = status_e'(m_axis_tdata_o[1:0]);
        got.done        = m_axis_tdata_o[2];
        got.covered     = m_axis_tdata_o[18:3];
        got.orphans     = m_axis_tdata_o[50:19];
        got.range_fails = m_axis_tdata_o[82:51];
        got.matched     = m_axis_tdata_o[114:83];
        if (pending_verdicts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: result with nothing pending, tdata %h", m_axis_tdata_o);
          end
        end else begin
          want = pending_verdicts.pop_front();
          if (got.status !== want.status || got.done !== want.done ||
              got.covered !== want.covered || got.orphans !== want.orphans ||
              got.range_fails !== want.range_fails || got.matched !== want.matched) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch: expected st %0d done %0d cov %0d orph %0d rf %0d ok %0d",
                       want.status, want.done, want.covered, want.orphans,
                       want.range_fails, want.matched);
              $display("          actual   st %0d done %0d cov %0d orph %0d rf %0d ok %0d",
                       got.status, got.done, got.covered, got.orphans,
                       got.range_fails, got.matched);
            end
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

endmodule
